[design/gpe_pkg.sv]
// Package for the gaussian population encoder.
// Holds shared types, register codes, fixed constants and the exp2 table function.
// No dependencies; all other design files but gpe_checker.sv import it.
package gpe_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_CENTERS = 8'd2;

    localparam logic [15:0] RST_MIN_VALUE   = 16'd0;
    localparam logic [15:0] RST_MAX_VALUE   = 16'd256;
    localparam logic [4:0]  RST_NUM_CENTERS = 5'd8;

    localparam int          DIV_STEPS = 41;
    localparam logic [5:0]  DIV_LAST  = 6'(DIV_STEPS - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_LOAD,
        DRV_SPACING,
        DRV_RECIP
    } drv_state_t;

    typedef struct packed {
        logic [15:0] min_value;
        logic [4:0]  count;
        logic [31:0] spacing;
        logic [31:0] recip;
        logic        busy;
    } cfg_t;

    typedef struct packed {
        logic [15:0] feature;
        logic        vend;
        logic        zero;
    } item_t;

    typedef struct packed {
        logic [4:0] idx;
        logic       last;
        logic       vend;
        logic       zero;
    } tag_t;

    // Entry j of the 2^(-j/2^bits) table in Q1.31, from a truncated Taylor series.
    function automatic logic [31:0] exp2_entry(input int j, input int bits);
        logic [63:0]        y;
        logic [63:0]        term;
        logic [63:0]        hi;
        logic [63:0]        lo;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        y = (64'(j) * LN2_Q32) >> bits;
        term = 64'd1 << 32;
        sum = $signed(term);
        for (int k = 1; k <= 16; k++)
        begin
            hi = term >> 32;
            lo = term & 64'hFFFF_FFFF;
            term = (hi * y + ((lo * y) >> 32)) / 64'(k);
            if (k[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 64'sd0;
        rounded = $unsigned(sum) + 64'd1;
        return 32'(rounded >> 1);
    endfunction

endpackage

[design/gpe_channels.sv]
// Channel interfaces of the gaussian population encoder: features, results, configuration.
// Each carries valid, ready and its payload; depends on gpe_pkg for the configuration widths.
interface gpe_feature_if;
    logic        valid;
    logic        ready;
    logic [15:0] feature_value;
    logic        vector_end_in;

    modport source (output valid, feature_value, vector_end_in, input ready);
    modport sink (input valid, feature_value, vector_end_in, output ready);
endinterface

interface gpe_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] response;
    logic [3:0]  center_index;
    logic        last_of_feature;
    logic        vector_end_out;

    modport source (output valid, response, center_index, last_of_feature, vector_end_out,
                    input ready);
    modport sink (input valid, response, center_index, last_of_feature, vector_end_out,
                  output ready);
endinterface

interface gpe_cfg_if import gpe_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/gpe_derive.sv]
// Configuration registers and the derivation of spacing and its reciprocal.
// A shared restoring divider runs twice, when max exceeds min, after reset and after every write; uses gpe_pkg.
module gpe_derive import gpe_pkg::*; #(
    parameter int MAX_CENTERS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    gpe_cfg_if.sink   cfg,
    output cfg_t      prm
);

    logic [15:0]        min_reg;
    logic [15:0]        max_reg;
    logic [4:0]         num_reg;
    logic [31:0]        spacing_reg;
    logic [31:0]        recip_reg;
    drv_state_t         state_reg;
    drv_state_t         state_next;
    logic [40:0]        quo_reg;
    logic [31:0]        rem_reg;
    logic [31:0]        dvs_reg;
    logic [5:0]         step_reg;

    logic               wr;
    logic signed [16:0] span;
    logic               span_pos;
    logic [4:0]         count;
    logic               last_step;
    logic [32:0]        rem_shift;
    logic               fits;
    logic [31:0]        rem_next;
    logic [40:0]        quo_next;
    logic               busy;
    logic               div_load;
    logic               div_run;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid && cfg.ready;

    assign span = $signed({max_reg[15], max_reg}) - $signed({min_reg[15], min_reg});
    assign span_pos = !span[16] && (span != 17'sd0);

    always_comb
    begin
        if (num_reg < 5'd2)
            count = 5'd2;
        else if (int'(num_reg) > MAX_CENTERS)
            count = 5'(MAX_CENTERS);
        else
            count = num_reg;
    end

    assign last_step = (step_reg == DIV_LAST);
    assign rem_shift = {rem_reg, quo_reg[40]};
    assign fits = (rem_shift >= {1'b0, dvs_reg});
    assign rem_next = fits ? 32'(rem_shift - {1'b0, dvs_reg}) : rem_shift[31:0];
    assign quo_next = {quo_reg[39:0], fits};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DRV_IDLE:    state_next = DRV_IDLE;
            DRV_LOAD:    state_next = span_pos ? DRV_SPACING : DRV_IDLE;
            DRV_SPACING: state_next = last_step ? DRV_RECIP : DRV_SPACING;
            DRV_RECIP:   state_next = last_step ? DRV_IDLE : DRV_RECIP;
            default:     state_next = DRV_LOAD;
        endcase
        if (wr)
            state_next = DRV_LOAD;
    end

    always_comb
    begin
        busy = 1'b1;
        div_load = 1'b0;
        div_run = 1'b0;
        unique case (state_reg)
            DRV_IDLE:    busy = 1'b0;
            DRV_LOAD:    div_load = 1'b1;
            DRV_SPACING: div_run = 1'b1;
            DRV_RECIP:   div_run = 1'b1;
            default:     busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DRV_LOAD;
            min_reg <= RST_MIN_VALUE;
            max_reg <= RST_MAX_VALUE;
            num_reg <= RST_NUM_CENTERS;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                case (cfg.index)
                    REG_MIN_VALUE:   min_reg <= cfg.data;
                    REG_MAX_VALUE:   max_reg <= cfg.data;
                    REG_NUM_CENTERS: num_reg <= cfg.data[4:0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            quo_reg <= {9'd0, span[15:0], 16'd0};
            rem_reg <= '0;
            dvs_reg <= 32'(count - 5'd1);
            step_reg <= '0;
            if (!span_pos)
            begin
                spacing_reg <= '0;
                recip_reg <= '0;
            end
        end
        else if (div_run)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            step_reg <= step_reg + 6'd1;
            if (last_step)
            begin
                step_reg <= '0;
                if (state_reg == DRV_SPACING)
                begin
                    spacing_reg <= quo_next[31:0];
                    dvs_reg <= quo_next[31:0];
                    quo_reg <= {1'b1, 40'd0};
                    rem_reg <= '0;
                end
                else
                begin
                    recip_reg <= quo_next[31:0];
                end
            end
        end
    end

    assign prm.min_value = min_reg;
    assign prm.count = count;
    assign prm.spacing = spacing_reg;
    assign prm.recip = recip_reg;
    assign prm.busy = busy;

endmodule

[design/gpe_front.sv]
// Front end: accepts features, tags an empty centre range, and queues them for the back end.
// Uses gpe_pkg types and the feature channel interface.
module gpe_front import gpe_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    gpe_feature_if.sink  features,
    input  cfg_t         prm,
    output logic         q_valid,
    output item_t        q_item,
    input  logic         q_ready
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                push;
    logic                pop;
    item_t               item_next;

    assign features.ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH)) && !prm.busy;
    assign push = features.valid && features.ready;
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign pop = q_valid && q_ready;

    assign item_next.feature = features.feature_value;
    assign item_next.vend = features.vector_end_in;
    assign item_next.zero = (prm.spacing == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= item_next;
    end

endmodule

[design/gpe_back.sv]
// Back end: steps through the centres of each queued feature, one response a cycle while unstalled.
// Centre, distance, exponent, exp2 table lookup and rounding run in a stalling pipeline; uses gpe_pkg.
module gpe_back import gpe_pkg::*; #(
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          prm,
    input  logic          q_valid,
    input  item_t         q_item,
    output logic          q_ready,
    gpe_result_if.source  results
);

    localparam int TBL_SIZE = (1 << EXP_TABLE_BITS) + 1;
    localparam int RW = 16 - EXP_TABLE_BITS;
    localparam int PW = 32 + RW;
    localparam int TIW = EXP_TABLE_BITS + 1;
    localparam int NSTAGE = 9;
    localparam int BIG_STAGE = 4;

    logic [31:0] tbl [TBL_SIZE];

    for (genvar j = 0; j < TBL_SIZE; j++)
    begin : g_tbl
        localparam logic [31:0] ENTRY = exp2_entry(j, EXP_TABLE_BITS);
        assign tbl[j] = ENTRY;
    end

    logic               act_reg;
    logic [4:0]         f_reg;
    logic [31:0]        acc_reg;
    item_t              cur_reg;
    logic [NSTAGE-1:0]  vld_reg;
    tag_t               tag_reg [NSTAGE];
    logic [15:0]        x_reg;
    logic [31:0]        acc0_reg;
    logic [23:0]        dabs_reg;
    logic [47:0]        d2_reg;
    logic [47:0]        phi_reg;
    logic [31:0]        plo_reg;
    logic [19:0]        a_reg;
    logic [20:0]        t_reg;
    logic [31:0]        ia_reg;
    logic [31:0]        ib_reg;
    logic [RW-1:0]      rem_reg;
    logic [4:0]         k6_reg;
    logic [31:0]        ia7_reg;
    logic [PW-1:0]      prod_reg;
    logic [4:0]         k7_reg;
    logic [31:0]        v_reg;
    logic [4:0]         k8_reg;
    logic               out_valid_reg;
    logic [15:0]        resp_reg;
    logic [3:0]         idx_reg;
    logic               last_reg;
    logic               vend_reg;

    logic               en;
    logic               last_f;
    logic               load;
    logic               issue;
    tag_t               tag_next;
    tag_t               tag_big;
    logic signed [25:0] ctr;
    logic signed [26:0] delta;
    logic [23:0]        dabs_next;
    logic [47:0]        d2_next;
    logic [47:0]        phi_next;
    logic [63:0]        plo_full;
    logic [48:0]        a_full;
    logic               big_next;
    logic [36:0]        t_full;
    logic [15:0]        frac;
    logic [TIW-1:0]     idx_a;
    logic [TIW-1:0]     idx_b;
    logic [31:0]        diff;
    logic [PW-1:0]      prod_next;
    logic [31:0]        v_next;
    logic [5:0]         sh;
    logic [39:0]        rnd;
    logic [39:0]        rsum;
    logic [39:0]        shf;
    logic [15:0]        resp_next;

    assign en = !out_valid_reg || results.ready;
    assign last_f = (f_reg == prm.count - 5'd1);
    assign q_ready = en && (!act_reg || last_f);
    assign load = q_ready && q_valid;
    assign issue = en && act_reg;

    assign tag_next.idx = f_reg;
    assign tag_next.last = last_f;
    assign tag_next.vend = cur_reg.vend;
    assign tag_next.zero = cur_reg.zero;

    assign ctr = $signed({{2{prm.min_value[15]}}, prm.min_value, 8'd0})
               + $signed({2'b00, acc0_reg[31:8]});
    assign delta = $signed({{3{x_reg[15]}}, x_reg, 8'd0}) - $signed({ctr[25], ctr});
    assign dabs_next = delta[26] ? 24'(-delta) : 24'(delta);

    assign d2_next = {24'd0, dabs_reg} * {24'd0, dabs_reg};

    assign phi_next = {32'd0, d2_reg[47:32]} * {16'd0, prm.recip};
    assign plo_full = {32'd0, d2_reg[31:0]} * {32'd0, prm.recip};

    assign a_full = {1'b0, phi_reg} + {17'd0, plo_reg};
    assign big_next = |a_full[48:20];

    assign tag_big.idx = tag_reg[BIG_STAGE-1].idx;
    assign tag_big.last = tag_reg[BIG_STAGE-1].last;
    assign tag_big.vend = tag_reg[BIG_STAGE-1].vend;
    assign tag_big.zero = tag_reg[BIG_STAGE-1].zero | big_next;

    assign t_full = {17'd0, a_reg} * {20'd0, LOG2E_Q16};

    assign frac = t_reg[15:0];
    assign idx_a = {1'b0, frac[15 -: EXP_TABLE_BITS]};
    assign idx_b = idx_a + 1'b1;

    assign diff = ia_reg - ib_reg;
    assign prod_next = PW'(diff) * PW'(rem_reg);

    assign v_next = ia7_reg - 32'(prod_reg >> RW);

    assign sh = {1'b0, k8_reg} + 6'd15;
    assign rnd = 40'd1 << (sh - 6'd1);
    assign rsum = {8'd0, v_reg} + rnd;
    assign shf = rsum >> sh;
    assign resp_next = tag_reg[NSTAGE-1].zero ? 16'd0
                     : ((|shf[39:16]) ? 16'hFFFF : shf[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            if (load)
                act_reg <= 1'b1;
            else if (issue && last_f)
                act_reg <= 1'b0;
            vld_reg <= {vld_reg[NSTAGE-2:0], issue};
            out_valid_reg <= vld_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (load)
            begin
                cur_reg <= q_item;
                f_reg <= '0;
                acc_reg <= '0;
            end
            else if (issue)
            begin
                f_reg <= f_reg + 5'd1;
                acc_reg <= acc_reg + prm.spacing;
            end

            tag_reg[0] <= tag_next;
            for (int i = 1; i < NSTAGE; i++)
                tag_reg[i] <= (i == BIG_STAGE) ? tag_big : tag_reg[i-1];

            x_reg <= cur_reg.feature;
            acc0_reg <= acc_reg;
            dabs_reg <= dabs_next;
            d2_reg <= d2_next;
            phi_reg <= phi_next;
            plo_reg <= plo_full[63:32];
            a_reg <= a_full[19:0];
            t_reg <= t_full[36:16];
            ia_reg <= tbl[idx_a];
            ib_reg <= tbl[idx_b];
            rem_reg <= frac[RW-1:0];
            k6_reg <= t_reg[20:16];
            ia7_reg <= ia_reg;
            prod_reg <= prod_next;
            k7_reg <= k6_reg;
            v_reg <= v_next;
            k8_reg <= k7_reg;

            resp_reg <= resp_next;
            idx_reg <= 4'(tag_reg[NSTAGE-1].idx);
            last_reg <= tag_reg[NSTAGE-1].last;
            vend_reg <= tag_reg[NSTAGE-1].last & tag_reg[NSTAGE-1].vend;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.response = resp_reg;
    assign results.center_index = idx_reg;
    assign results.last_of_feature = last_reg;
    assign results.vector_end_out = vend_reg;

endmodule

[design/gaussian_population_encoder_core.sv]
// Each accepted feature produces N responses, one per clock unless the results stall, where
// N is num_centers clamped to the range 2 to MAX_CENTERS; a feature therefore holds the single
// response pipeline until its last centre is issued, and a four-entry queue in front of it
// takes the next features meanwhile. The first response of a feature passes from the queue
// through the current-feature register and the pipeline stages to the output register. After
// reset and every configuration write, a one-bit-per-cycle divider recomputes spacing and its
// reciprocal while no feature is accepted; configuration writes are always taken.
module gaussian_population_encoder_core import gpe_pkg::*; #(
    parameter int MAX_CENTERS = 16,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    gpe_feature_if.sink   features,
    gpe_result_if.source  results,
    gpe_cfg_if.sink       cfg
);

    cfg_t  prm;
    logic  q_valid;
    item_t q_item;
    logic  q_ready;

    gpe_derive #(
        .MAX_CENTERS(MAX_CENTERS)
    ) u_derive (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg),
        .prm(prm)
    );

    gpe_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .features(features),
        .prm(prm),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_ready(q_ready)
    );

    gpe_back #(
        .EXP_TABLE_BITS(EXP_TABLE_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .prm(prm),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_ready(q_ready),
        .results(results)
    );

endmodule

[design/gpe_checker.sv]
// Port-level checker for the gaussian population encoder, attached to the top level by bind.
// Watches only the feature and result channels; no package dependency.
module gpe_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] response,
    input logic [3:0]  center_index,
    input logic        last_of_feature
);

    logic [3:0] exp_idx_reg;
    logic [7:0] pend_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (out_xfer)
                exp_idx_reg <= last_of_feature ? 4'd0 : exp_idx_reg + 4'd1;
            if (in_xfer && !(out_xfer && last_of_feature))
                pend_reg <= pend_reg + 8'd1;
            else if (!in_xfer && out_xfer && last_of_feature)
                pend_reg <= pend_reg - 8'd1;
        end
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result valid dropped before its transfer.");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(response) && $stable(center_index)
                                    && $stable(last_of_feature))
        else $error("Result payload changed while stalled.");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> center_index == exp_idx_reg)
        else $error("Centre index out of sequence.");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 8'd0)
        else $error("Result offered with no feature outstanding.");

endmodule

bind gaussian_population_encoder_core gpe_checker u_gpe_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(features.valid),
    .in_ready(features.ready),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .response(results.response),
    .center_index(results.center_index),
    .last_of_feature(results.last_of_feature)
);

[bench/gpe_response_checker.sv]
// Response checker for the gaussian population encoder: watches the three channels,
// predicts every response of each accepted feature and compares it in order.
// Depends on gpe_pkg and the channel interfaces in gpe_channels.sv.
module gpe_response_checker import gpe_pkg::*; #(
    parameter int MAX_CENTERS = 16,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic   clk,
    input  logic   rst_n,
    gpe_feature_if features,
    gpe_result_if  results,
    gpe_cfg_if     cfg,
    output int     mismatch_count,
    output int     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        FRAC_SHIFT   = 16 - EXP_TABLE_BITS;
    localparam int        POW2_ENTRIES = (1 << EXP_TABLE_BITS) + 1;
    localparam bit [63:0] LN2_FIX      = 64'd2977044472;
    localparam bit [63:0] LOG2E_FIX    = 64'd94548;

    typedef struct packed {
        logic [15:0] response;
        logic [3:0]  center_index;
        logic        last_of_feature;
        logic        vector_end_out;
    } response_t;

    response_t          expected_responses[$];
    logic [31:0]        pow2_frac [POW2_ENTRIES];
    logic signed [15:0] first_centre;
    logic signed [15:0] last_centre;
    logic [4:0]         centre_word;
    logic [31:0]        spacing_q24;
    logic [31:0]        spacing_inv;

    function void fill_pow2_table();
        bit [63:0] y;
        bit [63:0] term;
        bit [63:0] hi;
        bit [63:0] lo;
        longint    sum;
        for (int j = 0; j < POW2_ENTRIES; j++)
        begin
            y = (64'(j) * LN2_FIX) >> EXP_TABLE_BITS;
            term = 64'd1 << 32;
            sum = longint'(term);
            for (int k = 1; k <= 16; k++)
            begin
                hi = term >> 32;
                lo = term & 64'hFFFF_FFFF;
                term = (hi * y + ((lo * y) >> 32)) / 64'(k);
                if (k % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            pow2_frac[j] = 32'(($unsigned(sum) + 64'd1) >> 1);
        end
    endfunction

    function int effective_count();
        int n;
        n = int'(centre_word);
        if (n < 2)
            n = 2;
        if (n > MAX_CENTERS)
            n = MAX_CENTERS;
        return n;
    endfunction

    function void update_spacing();
        longint span;
        span = longint'(last_centre) - longint'(first_centre);
        if (span <= 0)
        begin
            spacing_q24 = 32'd0;
            spacing_inv = 32'd0;
        end
        else
        begin
            spacing_q24 = 32'((64'(span) << 16) / 64'(effective_count() - 1));
            spacing_inv = (spacing_q24 != 32'd0) ? 32'((64'd1 << 40) / {32'd0, spacing_q24})
                                                 : 32'd0;
        end
    endfunction

    function automatic logic [15:0] gaussian_at(input logic signed [15:0] x, input int f);
        longint    centre_pos;
        longint    delta;
        bit [63:0] dist_sq;
        bit [63:0] expo;
        bit [63:0] scaled;
        bit [63:0] v;
        bit [63:0] ia;
        bit [63:0] ib;
        int        k;
        int        frac;
        int        idx;
        int        rem;
        int        sh;
        if (spacing_q24 == 32'd0)
            return 16'd0;
        centre_pos = longint'(first_centre) * 256
                   + longint'((64'(f) * {32'd0, spacing_q24}) >> 8);
        delta = longint'(x) * 256 - centre_pos;
        dist_sq = delta * delta;
        expo = (dist_sq >> 32) * {32'd0, spacing_inv}
             + (((dist_sq & 64'hFFFF_FFFF) * {32'd0, spacing_inv}) >> 32);
        if (expo >= (64'd16 << 16))
            return 16'd0;
        scaled = (expo * LOG2E_FIX) >> 16;
        k = int'(scaled >> 16);
        frac = int'(scaled & 64'hFFFF);
        idx = frac >> FRAC_SHIFT;
        rem = frac & ((1 << FRAC_SHIFT) - 1);
        ia = {32'd0, pow2_frac[idx]};
        ib = {32'd0, pow2_frac[idx + 1]};
        v = ia - (((ia - ib) * 64'(rem)) >> FRAC_SHIFT);
        sh = 15 + k;
        v = (v + (64'd1 << (sh - 1))) >> sh;
        return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function void apply_register_write(input logic [CFG_INDEX_W-1:0] reg_index,
                                       input logic [CFG_DATA_W-1:0] reg_data);
        case (reg_index)
            REG_MIN_VALUE:   first_centre = reg_data[15:0];
            REG_MAX_VALUE:   last_centre = reg_data[15:0];
            REG_NUM_CENTERS: centre_word = reg_data[4:0];
            default:         return;
        endcase
        update_spacing();
    endfunction

    function void queue_feature_responses(input logic [15:0] value, input logic vend);
        int        n;
        response_t r;
        n = effective_count();
        for (int f = 0; f < n; f++)
        begin
            r.response = gaussian_at(value, f);
            r.center_index = 4'(f);
            r.last_of_feature = (f == n - 1);
            r.vector_end_out = r.last_of_feature & vend;
            expected_responses.insert(expected_responses.size(), r);
        end
    endfunction

    function void check_response();
        response_t seen;
        response_t want;
        seen.response = results.response;
        seen.center_index = results.center_index;
        seen.last_of_feature = results.last_of_feature;
        seen.vector_end_out = results.vector_end_out;
        if (expected_responses.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: unexpected response %0d center %0d last %0b vend %0b", $realtime,
                         seen.response, seen.center_index, seen.last_of_feature,
                         seen.vector_end_out);
        end
        else
        begin
            want = expected_responses.pop_front();
            if (seen !== want)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"%0t: expected response %0d center %0d last %0b vend %0b, ",
                              "got %0d %0d %0b %0b"},
                             $realtime, want.response, want.center_index,
                             want.last_of_feature, want.vector_end_out, seen.response,
                             seen.center_index, seen.last_of_feature, seen.vector_end_out);
            end
        end
    endfunction

    initial
    begin
        fill_pow2_table();
        first_centre = RST_MIN_VALUE;
        last_centre = RST_MAX_VALUE;
        centre_word = RST_NUM_CENTERS;
        update_spacing();
        mismatch_count = 0;
        outstanding = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
                apply_register_write(cfg.index, cfg.data);
            if (features.valid && features.ready)
                queue_feature_responses(features.feature_value, features.vector_end_in);
            if (results.valid && results.ready)
                check_response();
            outstanding = expected_responses.size();
        end
    end

endmodule

[bench/tb_top.sv]
// Top of the gaussian population encoder bench: clock, reset, feature and register traffic,
// and the response sink with random stalls; the checker beside the block gives the verdict.
// Depends on gpe_pkg, gpe_channels.sv, the encoder core and gpe_response_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gpe_pkg::*;

    localparam int CENTERS_MAX = 16;
    localparam int TABLE_BITS  = 8;

    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_HEAVY
    } idle_style_t;

    logic        clk;
    logic        rst_n;
    int          mismatch_count;
    int          outstanding;
    bit          hold_results;
    bit          pressure_go;
    idle_style_t idle_mode = IDLE_LIGHT;

    gpe_feature_if features ();
    gpe_result_if  results ();
    gpe_cfg_if     cfg ();

    gaussian_population_encoder_core #(
        .MAX_CENTERS(CENTERS_MAX),
        .EXP_TABLE_BITS(TABLE_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .features(features),
        .results(results),
        .cfg(cfg)
    );

    gpe_response_checker #(
        .MAX_CENTERS(CENTERS_MAX),
        .EXP_TABLE_BITS(TABLE_BITS)
    ) response_check (
        .clk(clk),
        .rst_n(rst_n),
        .features(features),
        .results(results),
        .cfg(cfg),
        .mismatch_count(mismatch_count),
        .outstanding(outstanding)
    );

    function automatic int idle_draw();
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 18)) : 0;
            default:    return int'($urandom_range(0, 18));
        endcase
    endfunction

    function automatic int clamp_q88(input int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic logic [15:0] pick_feature(input int lo, input int hi);
        int span;
        int v;
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        span = hi - lo;
        if (span < 1)
            span = 256;
        v = lo - span / 4 + int'($urandom_range(0, span + span / 2));
        return 16'(clamp_q88(v));
    endfunction

    task automatic send_feature(input logic [15:0] value, input logic vend);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            features.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        features.valid <= 1'b1;
        features.feature_value <= value;
        features.vector_end_in <= vend;
        do
        begin
            @(posedge clk);
        end
        while (!features.ready);
    endtask

    task automatic cfg_transfer(input logic [CFG_INDEX_W-1:0] reg_index,
                                input logic [CFG_DATA_W-1:0] reg_data);
        cfg.valid <= 1'b1;
        cfg.index <= reg_index;
        cfg.data <= reg_data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
    endtask

    task automatic wait_idle();
        features.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);
    endtask

    task automatic configure(input int lo, input int hi, input logic [15:0] count_word,
                             input int unknown_writes);
        int i;
        wait_idle();
        cfg_transfer(REG_MIN_VALUE, 16'(lo));
        for (i = 0; i < unknown_writes; i++)
        begin
            if (i == 0)
                cfg_transfer({CFG_INDEX_W{1'b1}}, 16'($urandom));
            else
                cfg_transfer(CFG_INDEX_W'(REG_NUM_CENTERS + 1 + $urandom_range(0, 252)),
                             16'($urandom));
        end
        cfg_transfer(REG_MAX_VALUE, 16'(hi));
        cfg_transfer(REG_NUM_CENTERS, count_word);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        wait (pressure_go);
        hold_results <= 1'b1;
        repeat (400) @(posedge clk);
        hold_results <= 1'b0;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        results.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
                stall_left = idle_draw();
            if (hold_results)
                results.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= 1'b1;
        end
    end

    initial
    begin
        int          phase;
        int          i;
        int          lo;
        int          hi;
        logic [15:0] count_word;
        rst_n = 1'b0;
        features.valid <= 1'b0;
        features.feature_value <= 16'd0;
        features.vector_end_in <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_MIN_VALUE;
        cfg.data <= 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_mode = IDLE_LIGHT;
        send_feature(16'h0000, 1'b0);
        send_feature(16'h0100, 1'b1);
        send_feature(16'h0080, 1'b0);
        send_feature(16'h8000, 1'b1);
        send_feature(16'h7FFF, 1'b0);
        send_feature(16'hFFFF, 1'b1);
        send_feature(16'h0024, 1'b0);
        send_feature(16'h0049, 1'b1);

        configure(-32768, 32767, 16'd16, 0);
        idle_mode = IDLE_HEAVY;
        send_feature(16'h8000, 1'b0);
        send_feature(16'h7FFF, 1'b1);
        send_feature(16'h0000, 1'b1);

        configure(100, 100, 16'd31, 0);
        send_feature(16'h0064, 1'b1);
        send_feature(16'h0000, 1'b0);

        configure(500, -500, 16'hFFE1, 0);
        idle_mode = IDLE_NONE;
        send_feature(16'h0000, 1'b1);
        send_feature(16'h01F4, 1'b0);

        configure(0, 1, 16'd0, 2);
        send_feature(16'h0000, 1'b0);
        send_feature(16'h0001, 1'b1);
        send_feature(16'h0002, 1'b0);

        configure(-256, 256, 16'd5, 0);
        idle_mode = IDLE_LIGHT;
        send_feature(16'hFF00, 1'b0);
        send_feature(16'h0000, 1'b0);
        send_feature(16'h0100, 1'b1);
        send_feature(16'h7FFF, 1'b1);

        for (phase = 0; phase < 12; phase++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    hi = lo - int'($urandom_range(0, 512));
                end
                1:
                begin
                    lo = int'($urandom_range(0, 64768)) - 32768;
                    hi = lo + int'($urandom_range(1, 16));
                end
                2:
                begin
                    lo = -32768 + int'($urandom_range(0, 64));
                    hi = 32767 - int'($urandom_range(0, 64));
                end
                default:
                begin
                    lo = int'($urandom_range(0, 6144)) - 4096;
                    hi = lo + int'($urandom_range(64, 4096));
                end
            endcase
            lo = clamp_q88(lo);
            hi = clamp_q88(hi);
            count_word = 16'($urandom);
            count_word[4:0] = ($urandom_range(0, 4) == 0) ? 5'($urandom)
                                                          : 5'($urandom_range(2, 16));
            configure(lo, hi, count_word, ($urandom_range(0, 2) == 0) ? 1 : 0);
            idle_mode = idle_style_t'($urandom_range(0, 2));
            if (phase == 2)
            begin
                idle_mode = IDLE_NONE;
                pressure_go = 1'b1;
            end
            for (i = 0; i < 30; i++)
                send_feature(pick_feature(lo, hi), $urandom_range(0, 3) == 0);
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[gaussian_population_encoder_core.f]
design/gpe_pkg.sv
design/gpe_channels.sv
design/gpe_derive.sv
design/gpe_front.sv
design/gpe_back.sv
design/gaussian_population_encoder_core.sv
design/gpe_checker.sv
bench/gpe_response_checker.sv
bench/tb_top.sv
